[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared sizes, status codes and beat/control types for the frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // bitmap geometry
    localparam int WORDS     = 1024;
    localparam int WORD_BITS = 32;

    // field widths
    localparam int FRAME_W  = 15;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;

    // derived widths
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CNT_W  = $clog2(WORDS + 1);
    localparam int PTR_W  = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;

    // reset value of the word count register
    localparam logic [CFG_W-1:0] WORDS_IN_USE_RST = CFG_W'(1024);

    // request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 2'd3;

    // input beat
    typedef struct packed {
        logic               action;
        logic [FRAME_W-1:0] frame_number;
    } bfa_req_t;

    // result beat
    typedef struct packed {
        logic [FRAME_W-1:0]  granted_frame;
        logic [STATUS_W-1:0] status;
    } bfa_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic                load;    // latch request, set scan pointer
        logic                rd;      // read bitmap word at pointer
        logic                adv;     // step pointer to next word
        logic                commit;  // write updated word, report ok
        logic                reply;   // report error code, no change
        logic [STATUS_W-1:0] code;
    } bfa_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_free;    // latched action is a free
        logic ptr_oor;    // pointer at or beyond the active word count
        logic word_full;  // word under evaluation has no clear bit
        logic bit_set;    // addressed bit of the word is set
    } bfa_sts_t;

endpackage

[rtl/bitmap_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Bitmap page frame allocator: allocate lowest free frame from the hint word,
// free a given frame, one bit per frame in a word-wide RAM.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   start, busy, req              taken when start high and busy low
//  result    done, rsp                     one-cycle strobe, always taken
//  config    cfg_we, cfg_wdata             written when cfg_we high
//
//  free: load, scan (reply if out of range), read, evaluate, commit or reply
//  allocate: from the hint word, scan, read, evaluate, step past full words,
//  reply no free at the word count; the single RAM port reads, then writes
//  reset: no clearing pass, a fill mark makes never-written words read free
//  results cannot be stalled; a new request may be taken while a beat shows
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bfa_pkg::bfa_req_t         req,
    input  logic                      cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
    output logic                      done,
    output bfa_pkg::bfa_rsp_t         rsp
);
    import bfa_pkg::*;

    bfa_cmd_t cmd;
    bfa_sts_t sts;

    // sequencer
    bfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // bitmap datapath
    bfa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

[rtl/bfa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wdata,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bfa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer for allocate and free: scan, evaluate, then commit or reply.
// ----------------------------------------------------------------------------
module bfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_cmd_t cmd,
    output logic              busy
);
    import bfa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.ptr_oor)
                begin
                    cmd.reply  = 1'b1;
                    cmd.code   = sts.is_free ? ST_OUT_OF_RANGE : ST_NO_FREE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.is_free)
                begin
                    if (sts.bit_set)
                    begin
                        cmd.commit = 1'b1;
                    end
                    else
                    begin
                        cmd.reply = 1'b1;
                        cmd.code  = ST_NOT_ALLOCATED;
                    end
                    state_next = S_IDLE;
                end
                else if (sts.word_full)
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/bfa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_dp
// Bitmap store, hint, fill mark, scan pointer, word count and result beat.
// ----------------------------------------------------------------------------
module bfa_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bfa_pkg::bfa_req_t          req,
    input  logic                       cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0]  cfg_wdata,
    input  bfa_pkg::bfa_cmd_t          cmd,
    output bfa_pkg::bfa_sts_t          sts,
    output logic                       done,
    output bfa_pkg::bfa_rsp_t          rsp
);
    import bfa_pkg::*;

    // lowest clear bit of a word
    function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] b;
        b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

    logic [CFG_W-1:0]     words_in_use_reg;
    logic [CNT_W-1:0]     hint_reg;
    logic [CNT_W-1:0]     fill_reg;   // words at or above this were never written
    logic [PTR_W-1:0]     ptr_reg;
    logic                 free_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic                 done_reg;
    bfa_rsp_t             rsp_reg;

    logic [PTR_W-1:0]     limit;
    logic [PTR_W-1:0]     req_word;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] cur_word;
    logic [BIT_W-1:0]     alloc_bit;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] free_word;
    logic [WORD_BITS-1:0] wr_word;
    logic [FRAME_W-1:0]   grant;
    logic [PTR_W-1:0]     ptr_inc;

    // active word count, clamped to the store depth
    assign limit = (32'(words_in_use_reg) > 32'(WORDS)) ? PTR_W'(WORDS)
                                                         : PTR_W'(words_in_use_reg);

    // word index of the frame to free
    assign req_word = PTR_W'(req.frame_number / FRAME_W'(WORD_BITS));

    // word under evaluation, never-written words read as free
    assign cur_word   = (32'(ptr_reg) < 32'(fill_reg)) ? rdata : '0;
    assign alloc_bit  = lowest_clear(cur_word);
    assign alloc_word = cur_word | (WORD_BITS'(1) << alloc_bit);
    assign free_word  = cur_word & ~(WORD_BITS'(1) << bit_reg);
    assign wr_word    = free_reg ? free_word : alloc_word;
    assign ptr_inc    = ptr_reg + PTR_W'(1);
    assign grant      = FRAME_W'(32'(ptr_reg) * 32'(WORD_BITS) + 32'(alloc_bit));

    // bitmap store
    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .re    (cmd.rd),
        .addr  (ptr_reg[ADDR_W-1:0]),
        .wdata (wr_word),
        .rdata (rdata)
    );

    // status to controller
    assign sts.is_free   = free_reg;
    assign sts.ptr_oor   = (ptr_reg >= limit);
    assign sts.word_full = (cur_word == '1);
    assign sts.bit_set   = cur_word[bit_reg];

    // word count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= WORDS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            words_in_use_reg <= cfg_wdata;
        end
    end

    // hint and fill mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (free_reg)
            begin
                if (32'(ptr_reg) < 32'(hint_reg))
                begin
                    hint_reg <= CNT_W'(ptr_reg);
                end
            end
            else
            begin
                if (alloc_word == '1)
                begin
                    hint_reg <= CNT_W'(ptr_inc);
                end
                if (32'(ptr_reg) >= 32'(fill_reg))
                begin
                    fill_reg <= CNT_W'(ptr_inc);
                end
            end
        end
    end

    // request latch and scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            free_reg <= req.action;
            bit_reg  <= BIT_W'(req.frame_number % FRAME_W'(WORD_BITS));
            ptr_reg  <= (req.action == ACT_FREE) ? req_word : PTR_W'(hint_reg);
        end
        else if (cmd.adv)
        begin
            ptr_reg <= ptr_inc;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit | cmd.reply;
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.granted_frame <= free_reg ? '0 : grant;
            rsp_reg.status        <= ST_OK;
        end
        else if (cmd.reply)
        begin
            rsp_reg.granted_frame <= '0;
            rsp_reg.status        <= cmd.code;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[bench/bfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker
// Watches the request, config and result channels of the frame allocator,
// keeps its own copy of the bitmap and hint, predicts each result beat and
// compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module bfa_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  bfa_pkg::bfa_req_t         req,
    input  logic                      cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      done,
    input  bfa_pkg::bfa_rsp_t         rsp,
    output int                        fail_count,
    output int                        pending,
    output int                        results_checked
);
    import bfa_pkg::*;

    // shadow of the allocator state
    bit [WORD_BITS-1:0] frame_map [WORDS];
    int                 open_word;
    logic [CFG_W-1:0]   words_cfg;

    // results still owed by the block, oldest first
    bfa_rsp_t owed_rsp_q [$];

    int fails;
    int checked;

    assign fail_count      = fails;
    assign results_checked = checked;

    // apply one request to the shadow bitmap and return the result beat
    function automatic bfa_rsp_t apply_request(input bfa_req_t r);
        bfa_rsp_t res;
        int       span;
        int       w;
        int       b;
        int       pick;
        bit       hit;
        span = (int'(words_cfg) > WORDS) ? WORDS : int'(words_cfg);
        res.granted_frame = '0;
        res.status        = ST_NO_FREE;
        if (r.action == ACT_ALLOC)
        begin
            // first non-full word from the hint, lowest clear bit in it
            hit = 1'b0;
            for (w = open_word; w < span; w++)
            begin
                if (!hit && frame_map[w] != '1)
                begin
                    pick = 0;
                    for (b = WORD_BITS - 1; b >= 0; b--)
                        if (!frame_map[w][b])
                            pick = b;
                    frame_map[w][pick] = 1'b1;
                    if (frame_map[w] == '1)
                        open_word = w + 1;
                    res.granted_frame = FRAME_W'(w * WORD_BITS + pick);
                    res.status        = ST_OK;
                    hit               = 1'b1;
                end
            end
        end
        else
        begin
            w = int'(r.frame_number) / WORD_BITS;
            b = int'(r.frame_number) % WORD_BITS;
            if (w >= span)
                res.status = ST_OUT_OF_RANGE;
            else if (!frame_map[w][b])
                res.status = ST_NOT_ALLOCATED;
            else
            begin
                frame_map[w][b] = 1'b0;
                if (w < open_word)
                    open_word = w;
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bfa_rsp_t owed;
        if (!rst_n)
        begin
            // reset state: every frame free, hint at word zero
            for (int i = 0; i < WORDS; i++)
                frame_map[i] = '0;
            open_word = 0;
            words_cfg = WORDS_IN_USE_RST;
            owed_rsp_q.delete();
            fails     = 0;
            checked   = 0;
            pending  <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (done)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    $error("result beat with nothing outstanding: granted_frame %0d status %0d",
                           rsp.granted_frame, rsp.status);
                    fails++;
                end
                else
                begin
                    owed = owed_rsp_q.pop_front();
                    checked++;
                    if (rsp.granted_frame !== owed.granted_frame)
                    begin
                        $error("granted_frame mismatch: expected %0d actual %0d",
                               owed.granted_frame, rsp.granted_frame);
                        fails++;
                    end
                    if (rsp.status !== owed.status)
                    begin
                        $error("status mismatch: expected %0d actual %0d",
                               owed.status, rsp.status);
                        fails++;
                    end
                end
            end
            // word count register write
            if (cfg_we)
                words_cfg = cfg_wdata;
            // accepted request beat
            if (start && !busy)
                owed_rsp_q.push_back(apply_request(req));
            pending <= owed_rsp_q.size();
        end
    end

endmodule

[bench/tb_bitmap_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator
// Drives directed and random allocate/free beats into the frame allocator
// across many word-count settings (zero, one, small, full and oversized),
// with random sender gaps; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    bfa_req_t         req;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             done;
    bfa_rsp_t         rsp;

    int fail_count;
    int pending;
    int results_checked;

    int beats_sent;
    int settings_used;
    int total_fails;
    int drain_cycles;

    bitmap_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .rsp       (rsp)
    );

    bfa_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req             (req),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // 100 MHz clock
    always #5 clk = ~clk;

    // present one request beat and hold it until taken
    task automatic send_beat(input logic act, input logic [FRAME_W-1:0] fn);
        req   <= '{action: act, frame_number: fn};
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
    endtask

    // random sender gap after a taken beat, mostly short
    task automatic sender_gap();
        int sel;
        int gap;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            gap = 0;
        else if (sel < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every outstanding result has come back
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
    endtask

    // word count register write, block idle
    task automatic set_word_count(input int words);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(words);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // frame choice: mostly low frames that are likely taken, some edge and wild
    function automatic logic [FRAME_W-1:0] pick_frame(input int eff);
        int sel;
        int span;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return FRAME_W'($urandom_range(0, 32767));
        if (sel < 25)
            return FRAME_W'(eff * WORD_BITS + $urandom_range(0, 40) - 8);
        span = (eff == 0) ? 1 : ((eff > 8) ? 8 : eff);
        return FRAME_W'($urandom_range(0, span * WORD_BITS - 1));
    endfunction

    // random stretch under one word count setting
    task automatic run_phase(input int words, input int count, input int alloc_pct);
        int   eff;
        bit   no_gaps;
        logic act;
        set_word_count(words);
        eff     = (words > WORDS) ? WORDS : words;
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count)
        begin
            act = ($urandom_range(0, 99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
            send_beat(act, pick_frame(eff));
            if (!no_gaps)
                sender_gap();
        end
    endtask

    // stimulus and verdict
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        req           = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        beats_sent    = 0;
        settings_used = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset word count, grants, double free, top frame
        send_beat(ACT_ALLOC, FRAME_W'(0));
        send_beat(ACT_ALLOC, FRAME_W'(32767));
        sender_gap();
        send_beat(ACT_ALLOC, FRAME_W'(0));
        send_beat(ACT_FREE,  FRAME_W'(1));
        send_beat(ACT_FREE,  FRAME_W'(1));
        sender_gap();
        send_beat(ACT_ALLOC, FRAME_W'(0));
        send_beat(ACT_FREE,  FRAME_W'(32767));
        send_beat(ACT_FREE,  FRAME_W'(0));
        send_beat(ACT_ALLOC, FRAME_W'(0));

        // directed: zero words, nothing to grant and nothing in range
        set_word_count(0);
        send_beat(ACT_ALLOC, FRAME_W'(0));
        send_beat(ACT_FREE,  FRAME_W'(0));
        send_beat(ACT_FREE,  FRAME_W'(32767));

        // directed: oversized count clamps to the full bitmap
        set_word_count(2047);
        send_beat(ACT_FREE,  FRAME_W'(32767));
        send_beat(ACT_ALLOC, FRAME_W'(0));

        // directed: single word, just past and at the edge
        set_word_count(1);
        send_beat(ACT_FREE,  FRAME_W'(32));
        send_beat(ACT_FREE,  FRAME_W'(31));
        send_beat(ACT_ALLOC, FRAME_W'(0));

        // random: fill and drain small maps, shrink below the hint, go wide
        run_phase(1,    150, 70);
        run_phase(3,    300, 75);
        run_phase(2,    150, 60);
        run_phase(1024, 400, 60);
        run_phase(5,    300, 65);
        run_phase(0,     40, 50);
        run_phase(2047, 200, 55);
        run_phase(4,    300, 50);
        run_phase(1,    160, 40);

        // drain, then let the pipeline settle
        start <= 1'b0;
        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (pending != 0 && drain_cycles < 50000);
        repeat (10) @(posedge clk);

        total_fails = fail_count;
        if (pending != 0)
        begin
            $error("%0d result beats never arrived", pending);
            total_fails++;
        end

        $display("run covered %0d request beats under %0d word count writes,",
                 beats_sent, settings_used);
        $display("with %0d result beats checked and %0d mismatches", results_checked,
                 total_fails);
        if (total_fails == 0)
            $display("** bitmap_frame_allocator: PASSED **");
        else
            $display("** bitmap_frame_allocator: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #200_000_000;
        $display("** bitmap_frame_allocator: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_ctrl.sv
rtl/bfa_dp.sv
rtl/bitmap_frame_allocator.sv
bench/bfa_checker.sv
bench/tb_bitmap_frame_allocator.sv
